// ===== rtl/core/rpch_pkg.sv =====
// Shared widths, latencies, register indexes and record types for the ray/plane checker.
// Depends on nothing; every other file in rtl/core refers to it by scoped names.
package rpch_pkg;

    localparam int FRAC_BITS = 16;

    // Field widths
    localparam int EYE_W  = 32;
    localparam int RAY_W  = 18;
    localparam int NRM_W  = 18;
    localparam int GRID_W = 16;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // Datapath widths
    localparam int DOTE_W   = EYE_W + NRM_W + 2;
    localparam int DOTR_W   = RAY_W + NRM_W + 2;
    localparam int NUM_W    = DOTE_W + 1;
    localparam int NUM_LO_W = 27;
    localparam int NUM_HI_W = NUM_W - NUM_LO_W;
    localparam int DEN_W    = RAY_W + NRM_W;
    localparam int PROD_W   = RAY_W + NUM_W;
    localparam int Q_W      = 41;
    localparam int STEP_W   = Q_W + 1;
    localparam int SUM_W    = STEP_W + 2;
    localparam int DIF_W    = EYE_W + 1;
    localparam int SQ_W     = 2 * EYE_W;
    localparam int RAD_W    = SQ_W + 2;
    localparam int ROOT_W   = RAD_W / 2;
    localparam int REM_W    = ROOT_W + 2;
    localparam int IP_W     = EYE_W - FRAC_BITS;

    localparam logic [Q_W-1:0] STEP_CAP = {1'b1, {(Q_W-1){1'b0}}};

    // Latencies in register stages
    localparam int FRONT_LAT = 4;
    localparam int DIV_LAT   = Q_W + 1;
    localparam int MID_LAT   = 2;
    localparam int SQ_LAT    = 2;
    localparam int SQRT_LAT  = ROOT_W;
    localparam int GRID_LAT  = IP_W;
    localparam int TAIL_LAT  = SQ_LAT + SQRT_LAT;
    localparam int PAR_DLY   = TAIL_LAT - GRID_LAT;
    localparam int PIPE_LAT  = FRONT_LAT + DIV_LAT + MID_LAT + TAIL_LAT;

    // Register indexes
    localparam logic [2:0] REG_NORMAL_X     = 3'd0;
    localparam logic [2:0] REG_NORMAL_Y     = 3'd1;
    localparam logic [2:0] REG_NORMAL_Z     = 3'd2;
    localparam logic [2:0] REG_PLANE_HEIGHT = 3'd3;
    localparam logic [2:0] REG_OFFSET_X     = 3'd4;
    localparam logic [2:0] REG_OFFSET_Z     = 3'd5;
    localparam logic [2:0] REG_GRID_SIZE    = 3'd6;

    localparam logic [NRM_W-1:0]  NORMAL_Y_RST = NRM_W'(1) << FRAC_BITS;
    localparam logic [GRID_W-1:0] GRID_RST     = GRID_W'(30);

    typedef struct packed {
        logic [NRM_W-1:0]  normal_x;
        logic [NRM_W-1:0]  normal_y;
        logic [NRM_W-1:0]  normal_z;
        logic [EYE_W-1:0]  plane_height;
        logic [EYE_W-1:0]  offset_x;
        logic [EYE_W-1:0]  offset_z;
        logic [GRID_W-1:0] grid_size;
    } rpch_cfg_t;

    typedef struct packed {
        logic                        hit;
        logic [2:0]                  neg;
        logic [DEN_W-1:0]            den_mag;
        logic [2:0][PROD_W-1:0]      prod;
        logic [2:0][EYE_W-1:0]       eye;
    } rpch_front_t;

    typedef struct packed {
        logic                  hit;
        logic [2:0]            neg;
        logic [2:0][EYE_W-1:0] eye;
    } rpch_side_t;

    typedef struct packed {
        logic                  hit;
        logic [2:0][EYE_W-1:0] pnt;
        logic                  pos_x;
        logic                  pos_z;
    } rpch_tail_t;

    typedef struct packed {
        logic              hit;
        logic [EYE_W-1:0]  hit_x;
        logic [EYE_W-1:0]  hit_y;
        logic [EYE_W-1:0]  hit_z;
        logic [EYE_W-1:0]  distance;
        logic              dark_square;
    } rpch_res_t;

endpackage

// ===== rtl/core/rpch_if.sv =====
// Request channels of the ray/plane checker: rays in, results out.
// Depends on rpch_pkg for field widths.
interface rpch_ray_if;
    logic                        valid;
    logic                        ready;
    logic [rpch_pkg::EYE_W-1:0]  eye_x;
    logic [rpch_pkg::EYE_W-1:0]  eye_y;
    logic [rpch_pkg::EYE_W-1:0]  eye_z;
    logic [rpch_pkg::RAY_W-1:0]  ray_x;
    logic [rpch_pkg::RAY_W-1:0]  ray_y;
    logic [rpch_pkg::RAY_W-1:0]  ray_z;

    modport source (output valid, eye_x, eye_y, eye_z, ray_x, ray_y, ray_z, input ready);
    modport sink   (input valid, eye_x, eye_y, eye_z, ray_x, ray_y, ray_z, output ready);
endinterface

interface rpch_hit_if;
    logic                        valid;
    logic                        ready;
    logic                        hit;
    logic [rpch_pkg::EYE_W-1:0]  hit_x;
    logic [rpch_pkg::EYE_W-1:0]  hit_y;
    logic [rpch_pkg::EYE_W-1:0]  hit_z;
    logic [rpch_pkg::EYE_W-1:0]  distance;
    logic                        dark_square;

    modport source (output valid, hit, hit_x, hit_y, hit_z, distance, dark_square, input ready);
    modport sink   (input valid, hit, hit_x, hit_y, hit_z, distance, dark_square, output ready);
endinterface

// ===== rtl/core/rpch_front.sv =====
// Front end: dot products with the plane normal, numerator/denominator, step products.
// Four register stages; depends on rpch_pkg.
module rpch_front (
    input  logic                                  clk,
    input  logic                                  en,
    input  logic [2:0][rpch_pkg::EYE_W-1:0]       eye,
    input  logic [2:0][rpch_pkg::RAY_W-1:0]       ray,
    input  rpch_pkg::rpch_cfg_t                   cfg,
    output rpch_pkg::rpch_front_t                 front
);

    logic [2:0][rpch_pkg::NRM_W-1:0] nrm;

    // stage A
    logic signed [rpch_pkg::EYE_W+rpch_pkg::NRM_W-1:0] pe_reg [3];
    logic signed [rpch_pkg::RAY_W+rpch_pkg::NRM_W-1:0] pr_reg [3];
    logic [2:0][rpch_pkg::EYE_W-1:0] eye_a_reg;
    logic [2:0][rpch_pkg::RAY_W-1:0] ray_a_reg;

    // stage B
    logic signed [rpch_pkg::DOTR_W-1:0] den_next;
    logic signed [rpch_pkg::DOTE_W-1:0] dot_next;
    logic signed [rpch_pkg::NUM_W-1:0]  num_next;
    logic                                hit_b_reg;
    logic                                num_neg_b_reg;
    logic [rpch_pkg::NUM_W-1:0]          num_mag_b_reg;
    logic [rpch_pkg::DEN_W-1:0]          den_mag_b_reg;
    logic [2:0][rpch_pkg::RAY_W-1:0]     ray_mag_b_reg;
    logic [2:0]                          ray_neg_b_reg;
    logic [2:0][rpch_pkg::EYE_W-1:0]     eye_b_reg;

    // stage C
    logic [rpch_pkg::RAY_W+rpch_pkg::NUM_LO_W-1:0] plo_reg [3];
    logic [rpch_pkg::RAY_W+rpch_pkg::NUM_HI_W-1:0] phi_reg [3];
    logic                                hit_c_reg;
    logic [2:0]                          neg_c_reg;
    logic [rpch_pkg::DEN_W-1:0]          den_c_reg;
    logic [2:0][rpch_pkg::EYE_W-1:0]     eye_c_reg;

    // stage D
    rpch_pkg::rpch_front_t front_reg;

    assign nrm = {cfg.normal_z, cfg.normal_y, cfg.normal_x};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                pe_reg[k] <= $signed(eye[k]) * $signed(nrm[k]);
                pr_reg[k] <= $signed(ray[k]) * $signed(nrm[k]);
            end
            eye_a_reg <= eye;
            ray_a_reg <= ray;
        end
    end

    always_comb
    begin
        den_next = rpch_pkg::DOTR_W'(pr_reg[0]) + rpch_pkg::DOTR_W'(pr_reg[1])
                 + rpch_pkg::DOTR_W'(pr_reg[2]);
        dot_next = rpch_pkg::DOTE_W'(pe_reg[0]) + rpch_pkg::DOTE_W'(pe_reg[1])
                 + rpch_pkg::DOTE_W'(pe_reg[2]);
        num_next = (rpch_pkg::NUM_W'($signed(cfg.plane_height)) <<< rpch_pkg::FRAC_BITS)
                 - rpch_pkg::NUM_W'(dot_next);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_b_reg     <= den_next[rpch_pkg::DOTR_W-1];
            num_neg_b_reg <= num_next[rpch_pkg::NUM_W-1];
            num_mag_b_reg <= rpch_pkg::NUM_W'(num_next[rpch_pkg::NUM_W-1] ? -num_next : num_next);
            den_mag_b_reg <= rpch_pkg::DEN_W'(den_next[rpch_pkg::DOTR_W-1] ? -den_next : den_next);
            for (int k = 0; k < 3; k++)
            begin
                ray_neg_b_reg[k] <= ray_a_reg[k][rpch_pkg::RAY_W-1];
                ray_mag_b_reg[k] <= ray_a_reg[k][rpch_pkg::RAY_W-1] ? (~ray_a_reg[k] + 1'b1)
                                                                    : ray_a_reg[k];
            end
            eye_b_reg <= eye_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                plo_reg[k] <= ray_mag_b_reg[k] * num_mag_b_reg[rpch_pkg::NUM_LO_W-1:0];
                phi_reg[k] <= ray_mag_b_reg[k]
                            * num_mag_b_reg[rpch_pkg::NUM_W-1:rpch_pkg::NUM_LO_W];
                neg_c_reg[k] <= ray_neg_b_reg[k] ^ num_neg_b_reg ^ hit_b_reg;
            end
            hit_c_reg <= hit_b_reg;
            den_c_reg <= den_mag_b_reg;
            eye_c_reg <= eye_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                front_reg.prod[k] <= (rpch_pkg::PROD_W'(phi_reg[k]) << rpch_pkg::NUM_LO_W)
                                   + rpch_pkg::PROD_W'(plo_reg[k]);
            end
            front_reg.hit     <= hit_c_reg;
            front_reg.neg     <= neg_c_reg;
            front_reg.den_mag <= den_c_reg;
            front_reg.eye     <= eye_c_reg;
        end
    end

    assign front = front_reg;

endmodule

// ===== rtl/core/rpch_step_div.sv =====
// Pipelined restoring divider for one axis step, one quotient bit per stage, clamped.
// Depends on rpch_pkg.
module rpch_step_div (
    input  logic                          clk,
    input  logic                          en,
    input  logic [rpch_pkg::PROD_W-1:0]   prod,
    input  logic [rpch_pkg::DEN_W-1:0]    den,
    output logic [rpch_pkg::Q_W-1:0]      quot
);

    localparam int L = rpch_pkg::DIV_LAT - 1;

    logic [rpch_pkg::DEN_W-1:0] rem_reg [rpch_pkg::DIV_LAT];
    logic [rpch_pkg::Q_W-1:0]   low_reg [rpch_pkg::DIV_LAT];
    logic [rpch_pkg::Q_W-1:0]   q_reg   [rpch_pkg::DIV_LAT];
    logic [rpch_pkg::DEN_W-1:0] d_reg   [rpch_pkg::DIV_LAT];
    logic                       ovf_reg [rpch_pkg::DIV_LAT];

    // Quotient beyond Q_W bits is flagged up front; the stages then resolve the low bits.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= rpch_pkg::DEN_W'(prod[rpch_pkg::PROD_W-1:rpch_pkg::Q_W]);
            low_reg[0] <= prod[rpch_pkg::Q_W-1:0];
            q_reg[0]   <= '0;
            d_reg[0]   <= den;
            ovf_reg[0] <= rpch_pkg::DEN_W'(prod[rpch_pkg::PROD_W-1:rpch_pkg::Q_W]) >= den;
        end
    end

    for (genvar i = 1; i < rpch_pkg::DIV_LAT; i++)
    begin : g_stage
        logic [rpch_pkg::DEN_W:0]   trial;
        logic                       ge;
        logic [rpch_pkg::DEN_W-1:0] rem_next;

        always_comb
        begin
            trial    = {rem_reg[i-1], low_reg[i-1][rpch_pkg::Q_W-1]};
            ge       = trial >= {1'b0, d_reg[i-1]};
            rem_next = ge ? rpch_pkg::DEN_W'(trial - {1'b0, d_reg[i-1]})
                          : trial[rpch_pkg::DEN_W-1:0];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= rem_next;
                low_reg[i] <= {low_reg[i-1][rpch_pkg::Q_W-2:0], 1'b0};
                q_reg[i]   <= {q_reg[i-1][rpch_pkg::Q_W-2:0], ge};
                d_reg[i]   <= d_reg[i-1];
                ovf_reg[i] <= ovf_reg[i-1];
            end
        end
    end

    assign quot = (ovf_reg[L] || (q_reg[L][rpch_pkg::Q_W-1] && |q_reg[L][rpch_pkg::Q_W-2:0]))
                ? rpch_pkg::STEP_CAP : q_reg[L];

endmodule

// ===== rtl/core/rpch_sqrt.sv =====
// Pipelined digit-by-digit integer square root, one root bit per stage.
// Depends on rpch_pkg.
module rpch_sqrt (
    input  logic                          clk,
    input  logic                          en,
    input  logic [rpch_pkg::RAD_W-1:0]    rad,
    output logic [rpch_pkg::ROOT_W-1:0]   root
);

    logic [rpch_pkg::REM_W-1:0]  rem_reg  [rpch_pkg::SQRT_LAT];
    logic [rpch_pkg::ROOT_W-1:0] root_reg [rpch_pkg::SQRT_LAT];
    logic [rpch_pkg::RAD_W-1:0]  rad_reg  [rpch_pkg::SQRT_LAT];

    for (genvar s = 0; s < rpch_pkg::SQRT_LAT; s++)
    begin : g_stage
        logic [rpch_pkg::REM_W-1:0]  rem_in;
        logic [rpch_pkg::ROOT_W-1:0] root_in;
        logic [rpch_pkg::RAD_W-1:0]  rad_in;
        logic [rpch_pkg::REM_W+1:0]  acc;
        logic [rpch_pkg::REM_W+1:0]  trial;
        logic                        ge;

        if (s == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = rad;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
            assign rad_in  = rad_reg[s-1];
        end

        always_comb
        begin
            acc   = {rem_in, rad_in[rpch_pkg::RAD_W-1:rpch_pkg::RAD_W-2]};
            trial = {2'b00, root_in, 2'b01};
            ge    = acc >= trial;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= ge ? rpch_pkg::REM_W'(acc - trial) : acc[rpch_pkg::REM_W-1:0];
                root_reg[s] <= {root_in[rpch_pkg::ROOT_W-2:0], ge};
                rad_reg[s]  <= {rad_in[rpch_pkg::RAD_W-3:0], 2'b00};
            end
        end
    end

    assign root = root_reg[rpch_pkg::SQRT_LAT-1];

endmodule

// ===== rtl/core/rpch_grid_div.sv =====
// Pipelined divider of a grid coordinate by the square size; yields the quotient parity.
// Depends on rpch_pkg.
module rpch_grid_div (
    input  logic                          clk,
    input  logic                          en,
    input  logic [rpch_pkg::IP_W-1:0]     ip,
    input  logic [rpch_pkg::GRID_W-1:0]   grid,
    output logic                          odd
);

    logic [rpch_pkg::GRID_W-1:0] rem_reg [rpch_pkg::GRID_LAT];
    logic [rpch_pkg::IP_W-1:0]   num_reg [rpch_pkg::GRID_LAT];
    logic                        bit_reg [rpch_pkg::GRID_LAT];

    for (genvar s = 0; s < rpch_pkg::GRID_LAT; s++)
    begin : g_stage
        logic [rpch_pkg::GRID_W-1:0] rem_in;
        logic [rpch_pkg::IP_W-1:0]   num_in;
        logic [rpch_pkg::GRID_W:0]   acc;
        logic                        ge;

        if (s == 0)
        begin : g_first
            assign rem_in = '0;
            assign num_in = ip;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[s-1];
            assign num_in = num_reg[s-1];
        end

        always_comb
        begin
            acc = {rem_in, num_in[rpch_pkg::IP_W-1]};
            ge  = acc >= {1'b0, grid};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= ge ? rpch_pkg::GRID_W'(acc - {1'b0, grid})
                                 : acc[rpch_pkg::GRID_W-1:0];
                num_reg[s] <= {num_in[rpch_pkg::IP_W-2:0], 1'b0};
                bit_reg[s] <= ge;
            end
        end
    end

    // The last quotient bit decides the parity
    assign odd = bit_reg[rpch_pkg::GRID_LAT-1];

endmodule

// ===== rtl/core/ray_plane_checker_hit.sv =====
// Ray against plane with checkerboard shading, signed Q16.16 fixed point.
// Throughput: one ray per cycle; the pipeline advances as one while the two-entry
// output queue has room, so it stalls only when two results wait untaken.
// The 42-stage step divider and 33-stage square root set the depth.
// Reset (rst_n, async, active low) clears valid bits and the queue, and restores the
// configuration registers to their reset values.
module ray_plane_checker_hit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rpch_pkg::ADDR_W-1:0]   paddr,
    input  logic [rpch_pkg::DATA_W-1:0]   pwdata,
    output logic [rpch_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    rpch_ray_if.sink                      ray_in,
    rpch_hit_if.source                    hit_out
);

    localparam logic signed [rpch_pkg::SUM_W-1:0] S_MAX =
        {{(rpch_pkg::SUM_W-rpch_pkg::EYE_W+1){1'b0}}, {(rpch_pkg::EYE_W-1){1'b1}}};
    localparam logic signed [rpch_pkg::SUM_W-1:0] S_MIN =
        {{(rpch_pkg::SUM_W-rpch_pkg::EYE_W+1){1'b1}}, {(rpch_pkg::EYE_W-1){1'b0}}};

    function automatic logic [rpch_pkg::EYE_W-1:0] sat32(
        input logic signed [rpch_pkg::SUM_W-1:0] v);
        logic [rpch_pkg::EYE_W-1:0] r;
        if (v > S_MAX)
            r = S_MAX[rpch_pkg::EYE_W-1:0];
        else if (v < S_MIN)
            r = S_MIN[rpch_pkg::EYE_W-1:0];
        else
            r = rpch_pkg::EYE_W'(v);
        return r;
    endfunction

    // Configuration registers
    rpch_pkg::rpch_cfg_t cfg_reg;
    logic                cfg_wr;

    // Pipeline control
    logic                          en;
    logic [rpch_pkg::PIPE_LAT-1:0] vld_reg;

    // Front end
    logic [2:0][rpch_pkg::EYE_W-1:0] eye_in;
    logic [2:0][rpch_pkg::RAY_W-1:0] ray_in_v;
    rpch_pkg::rpch_front_t           front;

    // Divider and its side line
    logic [2:0][rpch_pkg::Q_W-1:0]   quot;
    rpch_pkg::rpch_side_t            side_reg [rpch_pkg::DIV_LAT];
    rpch_pkg::rpch_side_t            side_in;
    rpch_pkg::rpch_side_t            side_out;

    // Stage E: shifted hit point
    logic [2:0][rpch_pkg::EYE_W-1:0] offs;
    logic [2:0][rpch_pkg::EYE_W-1:0] pnt_next;
    logic [2:0][rpch_pkg::EYE_W-1:0] pnt_e_reg;
    logic [2:0][rpch_pkg::EYE_W-1:0] eye_e_reg;
    logic                            hit_e_reg;

    // Stage F: distances and grid coordinates
    logic [2:0][rpch_pkg::EYE_W-1:0] dmag_next;
    logic [2:0][rpch_pkg::EYE_W-1:0] dmag_reg;
    logic [rpch_pkg::IP_W-1:0]       ipx_next;
    logic [rpch_pkg::IP_W-1:0]       ipz_next;
    logic [rpch_pkg::IP_W-1:0]       ipx_reg;
    logic [rpch_pkg::IP_W-1:0]       ipz_reg;
    rpch_pkg::rpch_tail_t            tail_f_reg;

    // Stages G, H and the root
    logic [rpch_pkg::SQ_W-1:0]       sq_reg [3];
    logic [rpch_pkg::RAD_W-1:0]      rad_reg;
    logic [rpch_pkg::ROOT_W-1:0]     root;
    rpch_pkg::rpch_tail_t            tail_reg [rpch_pkg::TAIL_LAT];
    logic [rpch_pkg::GRID_W-1:0]     grid_eff;
    logic                            odd_x;
    logic                            odd_z;
    logic [1:0]                      par_reg [rpch_pkg::PAR_DLY];

    // Result and output queue
    rpch_pkg::rpch_res_t res;
    rpch_pkg::rpch_res_t fifo_reg [2];
    logic                wr_ptr_reg;
    logic                rd_ptr_reg;
    logic [1:0]          cnt_reg;
    logic                push;
    logic                pop;

    // ---------------------------------------------------------------- config port
    // Write on the access phase; address bits below the word are ignored.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.normal_x     <= '0;
            cfg_reg.normal_y     <= rpch_pkg::NORMAL_Y_RST;
            cfg_reg.normal_z     <= '0;
            cfg_reg.plane_height <= '0;
            cfg_reg.offset_x     <= '0;
            cfg_reg.offset_z     <= '0;
            cfg_reg.grid_size    <= rpch_pkg::GRID_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                rpch_pkg::REG_NORMAL_X:     cfg_reg.normal_x     <= pwdata[rpch_pkg::NRM_W-1:0];
                rpch_pkg::REG_NORMAL_Y:     cfg_reg.normal_y     <= pwdata[rpch_pkg::NRM_W-1:0];
                rpch_pkg::REG_NORMAL_Z:     cfg_reg.normal_z     <= pwdata[rpch_pkg::NRM_W-1:0];
                rpch_pkg::REG_PLANE_HEIGHT: cfg_reg.plane_height <= pwdata[rpch_pkg::EYE_W-1:0];
                rpch_pkg::REG_OFFSET_X:     cfg_reg.offset_x     <= pwdata[rpch_pkg::EYE_W-1:0];
                rpch_pkg::REG_OFFSET_Z:     cfg_reg.offset_z     <= pwdata[rpch_pkg::EYE_W-1:0];
                rpch_pkg::REG_GRID_SIZE:    cfg_reg.grid_size    <= pwdata[rpch_pkg::GRID_W-1:0];
                default:                    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            rpch_pkg::REG_NORMAL_X:     prdata = rpch_pkg::DATA_W'(cfg_reg.normal_x);
            rpch_pkg::REG_NORMAL_Y:     prdata = rpch_pkg::DATA_W'(cfg_reg.normal_y);
            rpch_pkg::REG_NORMAL_Z:     prdata = rpch_pkg::DATA_W'(cfg_reg.normal_z);
            rpch_pkg::REG_PLANE_HEIGHT: prdata = rpch_pkg::DATA_W'(cfg_reg.plane_height);
            rpch_pkg::REG_OFFSET_X:     prdata = rpch_pkg::DATA_W'(cfg_reg.offset_x);
            rpch_pkg::REG_OFFSET_Z:     prdata = rpch_pkg::DATA_W'(cfg_reg.offset_z);
            rpch_pkg::REG_GRID_SIZE:    prdata = rpch_pkg::DATA_W'(cfg_reg.grid_size);
            default:                    prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- pipeline control
    // Advance every stage together while the output queue has a free entry; the
    // queue can fill both entries, and a request is held off only while both are full.
    assign en           = (cnt_reg != 2'd2);
    assign ray_in.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[rpch_pkg::PIPE_LAT-2:0], ray_in.valid};
    end

    // ---------------------------------------------------------------- front end
    assign eye_in   = {ray_in.eye_z, ray_in.eye_y, ray_in.eye_x};
    assign ray_in_v = {ray_in.ray_z, ray_in.ray_y, ray_in.ray_x};

    rpch_front u_front (
        .clk   (clk),
        .en    (en),
        .eye   (eye_in),
        .ray   (ray_in_v),
        .cfg   (cfg_reg),
        .front (front)
    );

    // ---------------------------------------------------------------- step dividers
    for (genvar k = 0; k < 3; k++)
    begin : g_div
        rpch_step_div u_div (
            .clk  (clk),
            .en   (en),
            .prod (front.prod[k]),
            .den  (front.den_mag),
            .quot (quot[k])
        );
    end

    // Hold hit flag, step signs and eye point alongside the dividers
    assign side_in.hit = front.hit;
    assign side_in.neg = front.neg;
    assign side_in.eye = front.eye;
    assign side_out    = side_reg[rpch_pkg::DIV_LAT-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            for (int i = 1; i < rpch_pkg::DIV_LAT; i++)
                side_reg[i] <= side_reg[i-1];
        end
    end

    // ---------------------------------------------------------------- stage E
    // Apply the step sign, add eye and offset, saturate to 32 bits.
    assign offs = {cfg_reg.offset_z, {rpch_pkg::EYE_W{1'b0}}, cfg_reg.offset_x};

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            pnt_next[k] = sat32(rpch_pkg::SUM_W'($signed(side_out.eye[k]))
                        + (side_out.neg[k] ? -rpch_pkg::SUM_W'({1'b0, quot[k]})
                                           : rpch_pkg::SUM_W'({1'b0, quot[k]}))
                        + rpch_pkg::SUM_W'($signed(offs[k])));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pnt_e_reg <= pnt_next;
            eye_e_reg <= side_out.eye;
            hit_e_reg <= side_out.hit;
        end
    end

    // ---------------------------------------------------------------- stage F
    // Eye-to-point offsets as magnitudes; integer grid coordinates truncated toward zero.
    always_comb
    begin
        logic signed [rpch_pkg::DIF_W-1:0] dif;
        logic signed [rpch_pkg::DIF_W-1:0] hx_s;
        logic signed [rpch_pkg::DIF_W-1:0] hz_s;
        logic [rpch_pkg::EYE_W-1:0]        hx_m;
        logic [rpch_pkg::EYE_W-1:0]        hz_m;
        for (int k = 0; k < 3; k++)
        begin
            dif = rpch_pkg::DIF_W'($signed(eye_e_reg[k]))
                - rpch_pkg::DIF_W'($signed(pnt_e_reg[k]));
            dmag_next[k] = rpch_pkg::EYE_W'(dif[rpch_pkg::DIF_W-1] ? -dif : dif);
        end
        hx_s = rpch_pkg::DIF_W'($signed(pnt_e_reg[0]));
        hz_s = rpch_pkg::DIF_W'($signed(pnt_e_reg[2]));
        hx_m = rpch_pkg::EYE_W'(hx_s[rpch_pkg::DIF_W-1] ? -hx_s : hx_s);
        hz_m = rpch_pkg::EYE_W'(hz_s[rpch_pkg::DIF_W-1] ? -hz_s : hz_s);
        ipx_next = hx_m[rpch_pkg::EYE_W-1:rpch_pkg::FRAC_BITS];
        ipz_next = hz_m[rpch_pkg::EYE_W-1:rpch_pkg::FRAC_BITS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dmag_reg         <= dmag_next;
            ipx_reg          <= ipx_next;
            ipz_reg          <= ipz_next;
            tail_f_reg.hit   <= hit_e_reg;
            tail_f_reg.pnt   <= pnt_e_reg;
            tail_f_reg.pos_x <= !pnt_e_reg[0][rpch_pkg::EYE_W-1] && (pnt_e_reg[0] != '0);
            tail_f_reg.pos_z <= !pnt_e_reg[2][rpch_pkg::EYE_W-1] && (pnt_e_reg[2] != '0);
        end
    end

    // ---------------------------------------------------------------- stages G, H, root
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
                sq_reg[k] <= dmag_reg[k] * dmag_reg[k];
            rad_reg <= rpch_pkg::RAD_W'(sq_reg[0]) + rpch_pkg::RAD_W'(sq_reg[1])
                     + rpch_pkg::RAD_W'(sq_reg[2]);
        end
    end

    rpch_sqrt u_sqrt (
        .clk  (clk),
        .en   (en),
        .rad  (rad_reg),
        .root (root)
    );

    // Square size zero acts as one
    assign grid_eff = (cfg_reg.grid_size == '0) ? rpch_pkg::GRID_W'(1) : cfg_reg.grid_size;

    rpch_grid_div u_grid_x (
        .clk  (clk),
        .en   (en),
        .ip   (ipx_reg),
        .grid (grid_eff),
        .odd  (odd_x)
    );

    rpch_grid_div u_grid_z (
        .clk  (clk),
        .en   (en),
        .ip   (ipz_reg),
        .grid (grid_eff),
        .odd  (odd_z)
    );

    // Hold the point and flags alongside the root; delay parities to line up
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tail_reg[0] <= tail_f_reg;
            for (int i = 1; i < rpch_pkg::TAIL_LAT; i++)
                tail_reg[i] <= tail_reg[i-1];
            par_reg[0] <= {odd_z, odd_x};
            for (int i = 1; i < rpch_pkg::PAR_DLY; i++)
                par_reg[i] <= par_reg[i-1];
        end
    end

    // ---------------------------------------------------------------- result
    // Drop all fields to zero when the ray does not face the plane.
    always_comb
    begin
        rpch_pkg::rpch_tail_t t;
        logic [1:0]           p;
        t = tail_reg[rpch_pkg::TAIL_LAT-1];
        p = par_reg[rpch_pkg::PAR_DLY-1];
        res = '0;
        if (t.hit)
        begin
            res.hit         = 1'b1;
            res.hit_x       = t.pnt[0];
            res.hit_y       = t.pnt[1];
            res.hit_z       = t.pnt[2];
            res.distance    = root[rpch_pkg::ROOT_W-1] ? '1 : root[rpch_pkg::EYE_W-1:0];
            res.dark_square = p[0] ^ t.pos_x ^ t.pos_z ^ p[1];
        end
    end

    // ---------------------------------------------------------------- output queue
    assign push = en && vld_reg[rpch_pkg::PIPE_LAT-1];
    assign pop  = hit_out.valid && hit_out.ready;

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wr_ptr_reg] <= res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

    assign hit_out.valid       = (cnt_reg != 2'd0);
    assign hit_out.hit         = fifo_reg[rd_ptr_reg].hit;
    assign hit_out.hit_x       = fifo_reg[rd_ptr_reg].hit_x;
    assign hit_out.hit_y       = fifo_reg[rd_ptr_reg].hit_y;
    assign hit_out.hit_z       = fifo_reg[rd_ptr_reg].hit_z;
    assign hit_out.distance    = fifo_reg[rd_ptr_reg].distance;
    assign hit_out.dark_square = fifo_reg[rd_ptr_reg].dark_square;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'd2)
        else $error("output queue count out of range");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2) |-> !ray_in.ready)
        else $error("request accepted while output queue full");

    a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 2'd1))
        else $error("queue count missed a push");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (hit_out.valid && !hit_out.hit) |-> (hit_out.distance == '0
            && hit_out.dark_square == 1'b0 && hit_out.hit_x == '0
            && hit_out.hit_y == '0 && hit_out.hit_z == '0))
        else $error("miss result carries non-zero fields");
`endif

endmodule
